// ===== src/belf_pkg.sv =====
`default_nettype none
package belf_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] REG_TAB_SIZE     = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEX_MODE     = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic in_nul;
    logic slot_free;
    logic step_last;
  } sts_t;

  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== src/belf_ctrl.sv =====
`default_nettype none
module belf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire belf_pkg::sts_t sts,
  output      belf_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !sts.in_nul) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/belf_datapath.sv =====
`default_nettype none
module belf_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire belf_pkg::cfg_wr_t                cfg_wr,
  output      logic [belf_pkg::DataWidth-1:0]   cfg_rdata,
  input  wire logic [1:0]                       cfg_ridx,
  input  wire logic [7:0]                       in_byte,
  input  wire belf_pkg::cmd_t                   cmd,
  output      belf_pkg::sts_t                   sts,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [7:0]                       out_char,
  output      logic                             last
);

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'd0, d};
    end
    return 8'h57 + {4'd0, d};
  endfunction

  logic [5:0] tab_size;
  logic [7:0] screen_width;
  logic       hex_mode;
  logic [7:0] columns_left;
  logic [7:0] byte_q;
  logic [2:0] pos;
  logic [5:0] tab_cnt;

  logic [7:0] width;
  logic [5:0] eff_tab;
  logic       punct;
  logic [7:0] esc_char;
  logic [7:0] step_char;
  logic       step_last;
  logic [7:0] cl_next;

  assign width   = (screen_width == 8'd0) ? 8'd1 : screen_width;
  assign eff_tab = (tab_size == 6'd0) ? 6'd1 : ((tab_size > 6'd32) ? 6'd32 : tab_size);

  assign punct = (byte_q >= 8'h21 && byte_q <= 8'h2F) || (byte_q >= 8'h3A && byte_q <= 8'h40) ||
                 (byte_q >= 8'h5B && byte_q <= 8'h60) || (byte_q >= 8'h7B && byte_q <= 8'h7E);

  always_comb begin
    case (pos)
      3'd0:    esc_char = CH_SEMI;
      3'd1:    esc_char = CH_ZERO;
      3'd2:    esc_char = hex_mode ? CH_X : (CH_ZERO + {6'd0, byte_q[7:6]});
      3'd3:    esc_char = hex_mode ? hex_digit(byte_q[7:4]) : (CH_ZERO + {5'd0, byte_q[5:3]});
      3'd4:    esc_char = hex_mode ? hex_digit(byte_q[3:0]) : (CH_ZERO + {5'd0, byte_q[2:0]});
      default: esc_char = CH_SEMI;
    endcase
  end

  always_comb begin
    step_char = CH_LF;
    step_last = 1'b1;
    cl_next   = width;
    if (byte_q == CH_TAB) begin
      if (columns_left != 8'd0) begin
        step_char = CH_SP;
        step_last = (tab_cnt == 6'd1) && (columns_left != 8'd1);
        cl_next   = columns_left - 8'd1;
      end
    end else if (byte_q != CH_LF) begin
      if (columns_left == 8'd0) begin
        step_last = 1'b0;
      end else begin
        step_char = punct ? esc_char : byte_q;
        step_last = (pos == (punct ? 3'd5 : 3'd0));
        cl_next   = columns_left - 8'd1;
      end
    end
  end

  assign sts.in_nul    = (in_byte == 8'd0);
  assign sts.slot_free = !out_valid || out_ready;
  assign sts.step_last = step_last;

  always_comb begin
    unique case (cfg_ridx)
      belf_pkg::REG_TAB_SIZE:     cfg_rdata = {26'd0, tab_size};
      belf_pkg::REG_SCREEN_WIDTH: cfg_rdata = {24'd0, screen_width};
      belf_pkg::REG_HEX_MODE:     cfg_rdata = {31'd0, hex_mode};
      default:                    cfg_rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size     <= 6'd4;
      screen_width <= 8'd10;
      hex_mode     <= 1'b0;
      columns_left <= 8'd10;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr.en) begin
        unique case (cfg_wr.idx)
          belf_pkg::REG_TAB_SIZE: begin
            tab_size <= cfg_wr.data[5:0];
          end
          belf_pkg::REG_SCREEN_WIDTH: begin
            screen_width <= cfg_wr.data;
            columns_left <= (cfg_wr.data == 8'd0) ? 8'd1 : cfg_wr.data;
          end
          belf_pkg::REG_HEX_MODE: begin
            hex_mode <= cfg_wr.data[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.step) begin
        columns_left <= cl_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q  <= in_byte;
      pos     <= 3'd0;
      tab_cnt <= eff_tab;
    end else if (cmd.step) begin
      if (byte_q == CH_TAB) begin
        if (columns_left != 8'd0) begin
          tab_cnt <= tab_cnt - 6'd1;
        end
      end else if (columns_left != 8'd0) begin
        pos <= pos + 3'd1;
      end
    end
    if (cmd.step) begin
      out_char <= step_char;
      last     <= step_last;
    end
  end

endmodule
`default_nettype wire

// ===== src/byte_escape_line_folder_core.sv =====
`default_nettype none
// Each nonzero input byte is accepted while the block is idle, then emits one character
// per cycle while the output side keeps up, and a NUL byte is absorbed with no output.
// The accepted byte is registered, and its characters leave through the out_char register;
// one byte is in work at a time. Synchronous reset sets tab_size to 4, screen_width to 10,
// octal escapes and a full line of 10 free columns, and empties the output register.
module byte_escape_line_folder_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [belf_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [belf_pkg::DataWidth-1:0]   pwdata,
  output      logic [belf_pkg::DataWidth-1:0]   prdata,
  output      logic                             pready,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [7:0]                       in_byte,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [7:0]                       out_char,
  output      logic                             last
);

  belf_pkg::cfg_wr_t cfg_wr;
  belf_pkg::cmd_t    cmd;
  belf_pkg::sts_t    sts;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[3:2];
  assign cfg_wr.data = pwdata[7:0];

  belf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  belf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_rdata (prdata),
    .cfg_ridx  (paddr[3:2]),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule
`default_nettype wire
